// File: sv/dwdg_pkg.sv
// ----------------------------------------------------------------------------
// dwdg_pkg
// Shared types, field widths and register codes for the distance window
// debounce gate.
// ----------------------------------------------------------------------------
`default_nettype none

package dwdg_pkg;

  // Field widths
  localparam int unsigned DistW  = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 8;
  localparam int unsigned AddrW  = 8;
  localparam int unsigned CfgW   = 32;

  // Packed stream widths, rounded up to whole bytes
  localparam int unsigned InBits   = 1 + DistW + TimeW;
  localparam int unsigned InDataW  = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutBits  = 1 + CountW + DistW;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  // Register reset values
  localparam logic [DistW-1:0]  MinDistRst  = '0;
  localparam logic [DistW-1:0]  MaxDistRst  = '1;
  localparam logic [TimeW-1:0]  TimeoutRst  = TimeW'(100);
  localparam logic [CountW-1:0] RequiredRst = CountW'(3);

  // Configuration register indexes
  typedef enum logic [AddrW-1:0] {
    REG_MIN_DIST = 8'd0,
    REG_MAX_DIST = 8'd1,
    REG_TIMEOUT  = 8'd2,
    REG_REQUIRED = 8'd3
  } cfg_reg_t;

  // Item kinds carried on tuser
  typedef enum logic {
    MODE_UPDATE = 1'b0,
    MODE_QUERY  = 1'b1
  } mode_t;

  // One input item as held in the input register
  typedef struct packed {
    mode_t             mode;
    logic              measurement_ok;
    logic [DistW-1:0]  distance;
    logic [TimeW-1:0]  time_ms;
  } item_t;

endpackage : dwdg_pkg

`default_nettype wire

// File: sv/distance_window_debounce_gate_core.sv
// ----------------------------------------------------------------------------
// distance_window_debounce_gate_core
// Debounces range-sensor samples against a distance window with a staleness
// timeout, and answers confirmation queries.
// ----------------------------------------------------------------------------
//
// Usage:
//   in_*  : one item per transfer. in_tuser is the kind (0 update, 1 query).
//           Update items store a sample and advance the run count; query
//           items ask whether confirmation holds at in_tdata's time.
//   out_* : exactly one result per input item, in order.
//   cfg_* : register writes (index, data), taken every cycle (cfg_ready is
//           tied high); write only while no item is in flight.
// Path: each item passes the input register, then the result register, which
//   drives out_tvalid. Throughput: one item per cycle while out_tready is
//   high, set by the single state update step between the two registers.
// Stall: while out_tvalid is high and out_tready low, the result holds and
//   one more item may wait in the input register; in_tready then drops.
// Reset: rst_n low clears both pipeline valids, the sample state and sets
//   the registers to min 0, max 65535, timeout 100 ms, required 3.
//
`default_nettype none

module distance_window_debounce_gate_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input stream
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  // [0] measurement_ok, [16:1] distance, [48:17] time_ms, rest zero
  input  wire logic [dwdg_pkg::InDataW-1:0]   in_tdata,
  // [0] mode
  input  wire logic                           in_tuser,
  // result stream
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  // [0] is_confirmed, [8:1] run_count, [24:9] latest_distance, rest zero
  output      logic [dwdg_pkg::OutDataW-1:0]  out_tdata,
  // configuration writes
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [dwdg_pkg::AddrW-1:0]     cfg_addr,
  input  wire logic [dwdg_pkg::CfgW-1:0]      cfg_data
);

  localparam int unsigned DistW  = dwdg_pkg::DistW;
  localparam int unsigned TimeW  = dwdg_pkg::TimeW;
  localparam int unsigned CountW = dwdg_pkg::CountW;

  // Configuration registers
  logic [DistW-1:0]  min_dist_r;
  logic [DistW-1:0]  max_dist_r;
  logic [TimeW-1:0]  timeout_r;
  logic [CountW-1:0] required_r;

  // Sample state
  logic [DistW-1:0]  stored_dist_r, stored_dist_nxt;
  logic [TimeW-1:0]  stored_time_r, stored_time_nxt;
  logic [CountW-1:0] run_r, run_nxt;
  logic              have_r, have_nxt;
  logic              conf_r, conf_nxt;

  // Pipeline registers
  logic                  s1_valid_r;
  dwdg_pkg::item_t       s1_item_r;
  logic                  out_valid_r;
  logic [CountW-1:0]     out_run_r;
  logic [DistW-1:0]      out_dist_r;
  logic                  out_conf_r;

  logic              out_free;
  logic              advance;
  logic              in_fire;
  logic              cfg_fire;
  logic [TimeW-1:0]  age;
  logic              age_ok;
  logic              in_window;
  logic [CountW-1:0] run_base;
  logic              result_conf;

  // Handshake control
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Register configuration writes; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= dwdg_pkg::MinDistRst;
      max_dist_r <= dwdg_pkg::MaxDistRst;
      timeout_r  <= dwdg_pkg::TimeoutRst;
      required_r <= dwdg_pkg::RequiredRst;
    end else if (cfg_fire) begin
      unique case (cfg_addr)
        dwdg_pkg::REG_MIN_DIST: min_dist_r <= cfg_data[DistW-1:0];
        dwdg_pkg::REG_MAX_DIST: max_dist_r <= cfg_data[DistW-1:0];
        dwdg_pkg::REG_TIMEOUT:  timeout_r  <= cfg_data[TimeW-1:0];
        dwdg_pkg::REG_REQUIRED: required_r <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.mode           <= dwdg_pkg::mode_t'(in_tuser);
      s1_item_r.measurement_ok <= in_tdata[0];
      s1_item_r.distance       <= in_tdata[DistW:1];
      s1_item_r.time_ms        <= in_tdata[DistW+TimeW:DistW+1];
    end
  end

  // Age check and window test
  assign age       = s1_item_r.time_ms - stored_time_r;
  assign age_ok    = age <= timeout_r;
  assign in_window = s1_item_r.measurement_ok
                     && (s1_item_r.distance >= min_dist_r)
                     && (s1_item_r.distance <= max_dist_r);
  // Drop the run when the previous sample has gone stale
  assign run_base  = (have_r && !age_ok) ? '0 : run_r;

  // Next sample state and result
  always_comb begin
    stored_dist_nxt = stored_dist_r;
    stored_time_nxt = stored_time_r;
    run_nxt         = run_r;
    have_nxt        = have_r;
    conf_nxt        = conf_r;
    result_conf     = have_r && conf_r && age_ok;
    if (s1_item_r.mode == dwdg_pkg::MODE_UPDATE) begin
      stored_dist_nxt = s1_item_r.distance;
      stored_time_nxt = s1_item_r.time_ms;
      have_nxt        = 1'b1;
      if (in_window) begin
        // Saturate the run at the required count
        run_nxt  = (run_base < required_r) ? run_base + CountW'(1) : run_base;
        conf_nxt = run_nxt >= required_r;
      end else begin
        run_nxt  = '0;
        conf_nxt = 1'b0;
      end
      result_conf = conf_nxt;
    end
  end

  // Advance sample state with each item leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_dist_r <= '0;
      stored_time_r <= '0;
      run_r         <= '0;
      have_r        <= 1'b0;
      conf_r        <= 1'b0;
    end else if (advance) begin
      stored_dist_r <= stored_dist_nxt;
      stored_time_r <= stored_time_nxt;
      run_r         <= run_nxt;
      have_r        <= have_nxt;
      conf_r        <= conf_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_conf_r <= result_conf;
      out_run_r  <= run_nxt;
      out_dist_r <= stored_dist_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = dwdg_pkg::OutDataW'({out_dist_r, out_run_r, out_conf_r});

`ifndef SYNTH
  // A query leaves the sample state untouched
  a_query_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_item_r.mode == dwdg_pkg::MODE_QUERY |=>
      $stable(run_r) && $stable(conf_r) && $stable(stored_time_r)
      && $stable(stored_dist_r) && $stable(have_r))
    else $error("query changed sample state");

  // An update stores its timestamp and marks a sample as held
  a_update_stores: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_item_r.mode == dwdg_pkg::MODE_UPDATE |=>
      have_r && stored_time_r == $past(s1_item_r.time_ms))
    else $error("update did not store sample");

  // No run or confirmation without a stored sample
  a_run_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r != '0 || conf_r) |-> have_r)
    else $error("run or confirm set without sample");

  // A stalled result is not overwritten by the next item
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_run_r)
      && $stable(out_conf_r) && $stable(out_dist_r))
    else $error("result overwritten under stall");
`endif

endmodule : distance_window_debounce_gate_core

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the distance window debounce gate. Directed items
// cover the window bounds, run saturation, staleness across the 32-bit time
// wrap and the register corner cases. Random phases then follow, each with
// new register settings. A tracker object mirrors the sample state and
// checks every result transfer, field by field, in order.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int StallLimit = 1000;

  typedef struct packed {
    bit                         conf;
    bit [dwdg_pkg::CountW-1:0]  run;
    bit [dwdg_pkg::DistW-1:0]   dist_mm;
  } verdict_t;

  // Mirror of the debounce state; holds the verdicts still owed by the block
  class debounce_tracker;
    bit [dwdg_pkg::DistW-1:0]  win_lo;
    bit [dwdg_pkg::DistW-1:0]  win_hi;
    bit [dwdg_pkg::TimeW-1:0]  max_age;
    bit [dwdg_pkg::CountW-1:0] need;
    bit [dwdg_pkg::DistW-1:0]  last_dist;
    bit [dwdg_pkg::TimeW-1:0]  last_time;
    bit [dwdg_pkg::CountW-1:0] run;
    bit                        held;
    bit                        confirmed;
    verdict_t                  owed_verdicts[$];
    int                        errors;

    function new();
      win_lo  = dwdg_pkg::MinDistRst;
      win_hi  = dwdg_pkg::MaxDistRst;
      max_age = dwdg_pkg::TimeoutRst;
      need    = dwdg_pkg::RequiredRst;
    endfunction

    function void write_reg(logic [dwdg_pkg::AddrW-1:0] idx,
                            logic [dwdg_pkg::CfgW-1:0] val);
      case (idx)
        dwdg_pkg::REG_MIN_DIST: win_lo = val[dwdg_pkg::DistW-1:0];
        dwdg_pkg::REG_MAX_DIST: win_hi = val[dwdg_pkg::DistW-1:0];
        dwdg_pkg::REG_TIMEOUT:  max_age = val[dwdg_pkg::TimeW-1:0];
        dwdg_pkg::REG_REQUIRED: need = val[dwdg_pkg::CountW-1:0];
        default: ;
      endcase
    endfunction

    function bit fresh(bit [dwdg_pkg::TimeW-1:0] now);
      bit [dwdg_pkg::TimeW-1:0] age;
      age = now - last_time;
      return age <= max_age;
    endfunction

    // Advance the mirror by one accepted item and queue its verdict
    function void accept_sample(dwdg_pkg::mode_t m, bit ok,
                                bit [dwdg_pkg::DistW-1:0] d,
                                bit [dwdg_pkg::TimeW-1:0] t);
      verdict_t v;
      if (m == dwdg_pkg::MODE_UPDATE) begin
        if (held && !fresh(t)) begin
          run = '0;
          confirmed = 1'b0;
        end
        last_dist = d;
        last_time = t;
        held = 1'b1;
        if (ok && d >= win_lo && d <= win_hi) begin
          if (run < need) run = run + 8'd1;
          confirmed = (run >= need);
        end else begin
          run = '0;
          confirmed = 1'b0;
        end
        v.conf = confirmed;
      end else begin
        v.conf = held && confirmed && fresh(t);
      end
      v.run     = run;
      v.dist_mm = last_dist;
      owed_verdicts.push_back(v);
    endfunction

    function void check_verdict(logic [dwdg_pkg::OutDataW-1:0] data);
      verdict_t want;
      if (owed_verdicts.size() == 0) begin
        errors++;
        $display("%0t: result %h with nothing expected", $time, data);
        return;
      end
      want = owed_verdicts.pop_front();
      if (data[0] !== want.conf) begin
        errors++;
        $display("%0t: is_confirmed expected %0d actual %0d", $time, want.conf, data[0]);
      end
      if (data[8:1] !== want.run) begin
        errors++;
        $display("%0t: run_count expected %0d actual %0d", $time, want.run, data[8:1]);
      end
      if (data[24:9] !== want.dist_mm) begin
        errors++;
        $display("%0t: latest_distance expected %0d actual %0d", $time, want.dist_mm,
                 data[24:9]);
      end
    endfunction

    function int outstanding();
      return owed_verdicts.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [dwdg_pkg::InDataW-1:0]   in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [dwdg_pkg::OutDataW-1:0]  out_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [dwdg_pkg::AddrW-1:0]     cfg_addr = '0;
  logic [dwdg_pkg::CfgW-1:0]      cfg_data = '0;

  debounce_tracker tracker = new();
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold = 0;
  int idle_cycles = 0;

  distance_window_debounce_gate_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Offer one item after a random gap; note it once the transfer happens
  task automatic send_item(dwdg_pkg::mode_t m, bit ok, bit [dwdg_pkg::DistW-1:0] d,
                           bit [dwdg_pkg::TimeW-1:0] t);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= dwdg_pkg::InDataW'({t, d, ok});
    do @(posedge clk); while (!in_tready);
    tracker.accept_sample(m, ok, d, t);
  endtask

  task automatic write_reg(logic [dwdg_pkg::AddrW-1:0] idx,
                           logic [dwdg_pkg::CfgW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering and let every owed result drain out of the pipeline
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic bit [dwdg_pkg::TimeW-1:0] time_step(bit [dwdg_pkg::TimeW-1:0] lim);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, (lim > 1000) ? 1000 : lim);
    else if (r == 6) return lim;
    else if (r == 7) return lim + 1;
    else if (r == 8) return $urandom;
    return '0;
  endfunction

  function automatic bit [dwdg_pkg::DistW-1:0] pick_distance(bit [dwdg_pkg::DistW-1:0] lo,
                                                             bit [dwdg_pkg::DistW-1:0] hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6 && lo <= hi) return 16'($urandom_range(lo, hi));
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: return lo;
        1: return hi;
        2: return lo - 1'b1;
        default: return hi + 1'b1;
      endcase
    end
    return 16'($urandom);
  endfunction

  // Receiver: stall a random number of cycles per result, then take it
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) stall = rx_hold;
      else stall = rx_idle_en ? $urandom_range(0, 11) : 0;
      rx_hold = 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_verdict(out_tdata);
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit [dwdg_pkg::TimeW-1:0] now;
    bit [dwdg_pkg::TimeW-1:0] t;
    bit [dwdg_pkg::DistW-1:0] lo;
    bit [dwdg_pkg::DistW-1:0] hi;
    dwdg_pkg::mode_t          m;
    bit                       ok;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default settings: window bounds, saturation, freshness edge
    send_item(dwdg_pkg::MODE_QUERY,  1'b0, 16'd0,     32'd0);
    send_item(dwdg_pkg::MODE_UPDATE, 1'b1, 16'd0,     32'd0);
    send_item(dwdg_pkg::MODE_UPDATE, 1'b1, 16'hFFFF,  32'd10);
    send_item(dwdg_pkg::MODE_UPDATE, 1'b1, 16'd1000,  32'd20);
    send_item(dwdg_pkg::MODE_UPDATE, 1'b1, 16'd1234,  32'd30);
    send_item(dwdg_pkg::MODE_QUERY,  1'b0, 16'd0,     32'd130);
    send_item(dwdg_pkg::MODE_QUERY,  1'b0, 16'd0,     32'd131);
    send_item(dwdg_pkg::MODE_QUERY,  1'b1, 16'hFFFF,  32'hFFFF_FFFF);
    // Stale sample, invalid measurement, then freshness across the time wrap
    send_item(dwdg_pkg::MODE_UPDATE, 1'b1, 16'd500,   32'd400);
    send_item(dwdg_pkg::MODE_UPDATE, 1'b0, 16'd500,   32'd410);
    send_item(dwdg_pkg::MODE_UPDATE, 1'b1, 16'd7,     32'hFFFF_FFC0);
    send_item(dwdg_pkg::MODE_UPDATE, 1'b1, 16'd7,     32'h0000_0010);
    settle();

    // Narrow window, single sample needed, zero timeout, ignored indexes
    write_reg(dwdg_pkg::REG_MIN_DIST, 32'd1000);
    write_reg(dwdg_pkg::REG_MAX_DIST, 32'd2000);
    write_reg(dwdg_pkg::REG_REQUIRED, 32'd1);
    write_reg(dwdg_pkg::REG_TIMEOUT, 32'd0);
    write_reg(8'd4, 32'h0000_5555);
    write_reg(8'hFF, 32'hFFFF_FFFF);
    send_item(dwdg_pkg::MODE_UPDATE, 1'b1, 16'd999,   32'h10);
    send_item(dwdg_pkg::MODE_UPDATE, 1'b1, 16'd1000,  32'h10);
    send_item(dwdg_pkg::MODE_UPDATE, 1'b1, 16'd2000,  32'h10);
    send_item(dwdg_pkg::MODE_UPDATE, 1'b1, 16'd2001,  32'h10);
    send_item(dwdg_pkg::MODE_UPDATE, 1'b1, 16'd1500,  32'h11);
    settle();

    // Inverted window rejects everything
    write_reg(dwdg_pkg::REG_MIN_DIST, 32'd3000);
    write_reg(dwdg_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(dwdg_pkg::REG_REQUIRED, 32'd0);
    send_item(dwdg_pkg::MODE_UPDATE, 1'b1, 16'd2500,  32'd0);
    settle();

    // Zero required samples confirms without counting
    write_reg(dwdg_pkg::REG_MIN_DIST, 32'd0);
    write_reg(dwdg_pkg::REG_MAX_DIST, 32'hFFFF);
    send_item(dwdg_pkg::MODE_UPDATE, 1'b1, 16'd2500,  32'd5);
    settle();

    // Lower the requirement below the current run
    write_reg(dwdg_pkg::REG_REQUIRED, 32'd5);
    repeat (4) send_item(dwdg_pkg::MODE_UPDATE, 1'b1, 16'd100, 32'd6);
    settle();
    write_reg(dwdg_pkg::REG_REQUIRED, 32'd2);
    send_item(dwdg_pkg::MODE_UPDATE, 1'b1, 16'd100,   32'd7);
    send_item(dwdg_pkg::MODE_QUERY,  1'b0, 16'd0,     32'h8000_0000);

    // Random phases, each with fresh settings
    for (int ph = 0; ph < 10; ph++) begin
      settle();
      case ($urandom_range(0, 3))
        0: begin lo = 16'd0; hi = 16'hFFFF; end
        1: begin
          lo = 16'($urandom_range(0, 60000));
          hi = lo + 16'($urandom_range(0, 5000));
        end
        2: begin
          hi = 16'($urandom_range(0, 60000));
          lo = hi + 16'($urandom_range(1, 5000));
        end
        default: begin lo = 16'($urandom); hi = lo; end
      endcase
      write_reg(dwdg_pkg::REG_MIN_DIST, {16'($urandom), lo});
      write_reg(dwdg_pkg::REG_MAX_DIST, {16'($urandom), hi});
      case ($urandom_range(0, 3))
        0: write_reg(dwdg_pkg::REG_TIMEOUT, 32'd0);
        1: write_reg(dwdg_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
        2: write_reg(dwdg_pkg::REG_TIMEOUT, $urandom_range(1, 500));
        default: write_reg(dwdg_pkg::REG_TIMEOUT, $urandom);
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(dwdg_pkg::REG_REQUIRED, 32'd0);
        1: write_reg(dwdg_pkg::REG_REQUIRED, 32'd255);
        default: write_reg(dwdg_pkg::REG_REQUIRED,
                           {24'($urandom), 8'($urandom_range(1, 6))});
      endcase
      write_reg(8'($urandom_range(4, 255)), $urandom);
      tx_idle_en = (ph % 3 != 1);
      rx_idle_en = (ph % 4 != 2);
      now = $urandom;

      for (int k = 0; k < 50; k++) begin
        // Hold off the receiver while the sender keeps pushing back to back
        if (ph == 2 && k == 10) begin
          rx_hold = 80;
          tx_idle_en = 1'b0;
        end
        if (ph == 2 && k == 35) tx_idle_en = 1'b1;
        // Pause the sender until the pipeline is empty
        if (ph == 3 && k == 25) settle();

        m  = ($urandom_range(0, 3) == 0) ? dwdg_pkg::MODE_QUERY : dwdg_pkg::MODE_UPDATE;
        ok = ($urandom_range(0, 9) != 0);
        t  = now + time_step(tracker.max_age);
        if (m == dwdg_pkg::MODE_UPDATE) now = t;
        send_item(m, ok, pick_distance(tracker.win_lo, tracker.win_hi), t);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
